// ===== hdl/phs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position history stack package
// Shared sizes, opcode and status codes for the position history stack.
// ----------------------------------------------------------------------------
package phs_pkg;

  localparam int DEPTH      = 64;
  localparam int COORD_BITS = 16;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW         = $clog2(DEPTH + 1);
  localparam int NW         = (CW > 7) ? CW : 7;
  localparam int EW         = 2 * COORD_BITS;

  typedef enum logic [2:0] {
    OP_MOVE   = 3'd0,
    OP_DROP   = 3'd1,
    OP_POP    = 3'd2,
    OP_DELETE = 3'd3,
    OP_KEEP   = 3'd4,
    OP_REMOVE = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

endpackage

// ===== hdl/position_history_stack_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position history stack
// Bounded stack of 2D positions with indexed delete and tail trimming.
// ----------------------------------------------------------------------------
// One request is taken at a time. Drop, remove-last, a keep-last that changes
// nothing and any request that is rejected finish in the execute state; move
// and pop also read the newest entry from the store, except a move onto an
// empty history. Delete-at and keep-last move the surviving entries through
// the store one per cycle in the copy state. The store itself is the limit:
// it has one read and one write port, and the copy sequencer streams one
// entry through it per cycle. The block is ready again in the same cycle
// that a result is presented. A new request is accepted while an earlier
// result still waits.
module position_history_stack_top
  import phs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] step_x_i,
  input  logic [15:0] step_y_i,
  input  logic [5:0]  entry_index_i,
  input  logic [6:0]  entry_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_x_o,
  output logic [15:0] out_y_o,
  output logic [1:0]  status_o,
  output logic [6:0]  fill_count_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_COPY   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [AW-1:0] src_q, src_d;
  logic [AW-1:0] dst_q, dst_d;
  logic [AW-1:0] pdst_q, pdst_d;
  logic          pend_q, pend_d;
  logic          e0_q, e0_d;
  logic          rdz_q, rdz_d;

  opcode_e       op_q;
  logic [15:0]   sx_q, sy_q;
  logic [5:0]    idx_q;
  logic [6:0]    n_q;

  logic [15:0]   res_x_q, res_x_d;
  logic [15:0]   res_y_q, res_y_d;
  status_e       res_st_q, res_st_d;

  logic          out_valid_q;
  logic [15:0]   out_x_q, out_y_q;
  logic [1:0]    out_st_q;
  logic [6:0]    out_fill_q;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata, rd_eff;
  logic [EW-1:0] add_base, add_sum;

  logic [NW-1:0] cnt_ext, n_ext, idx_ext, depth_ext;
  logic          out_slot_free;

  assign cnt_ext       = NW'(count_q);
  assign n_ext         = NW'(n_q);
  assign idx_ext       = NW'(idx_q);
  assign depth_ext     = NW'(DEPTH);
  assign rd_eff        = rdz_q ? '0 : ram_rdata;
  assign add_base      = (state_q == S_EXEC) ? '0 : rd_eff;
  assign out_slot_free = !out_valid_q || out_ready_i;

  phs_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  phs_coord_add u_add (
    .base_i   (add_base),
    .step_x_i (sx_q),
    .step_y_i (sy_q),
    .sum_o    (add_sum)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rem_d     = rem_q;
    src_d     = src_q;
    dst_d     = dst_q;
    pdst_d    = pdst_q;
    pend_d    = 1'b0;
    res_x_d   = res_x_q;
    res_y_d   = res_y_q;
    res_st_d  = res_st_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = add_sum;
    ram_re    = 1'b0;
    ram_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_x_d  = '0;
        res_y_d  = '0;
        res_st_d = ST_DONE;
        state_d  = S_DONE;
        case (op_q)
          OP_MOVE: begin
            if (cnt_ext >= depth_ext) begin
              res_st_d = ST_FULL;
            end else if (count_q == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              count_d   = CW'(1);
            end else begin
              ram_re    = 1'b1;
              ram_raddr = AW'(count_q - CW'(1));
              state_d   = S_RDWAIT;
            end
          end
          OP_DROP: begin
            if (count_q == '0) begin
              res_st_d = ST_EMPTY;
            end else begin
              count_d = count_q - CW'(1);
            end
          end
          OP_POP: begin
            if (count_q == '0) begin
              res_st_d = ST_EMPTY;
              res_x_d  = '1;
              res_y_d  = '1;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = AW'(count_q - CW'(1));
              count_d   = count_q - CW'(1);
              state_d   = S_RDWAIT;
            end
          end
          OP_DELETE: begin
            if (idx_ext >= cnt_ext) begin
              res_st_d = ST_RANGE;
            end else begin
              src_d   = AW'(idx_q) + AW'(1);
              dst_d   = AW'(idx_q);
              rem_d   = CW'(cnt_ext - idx_ext - NW'(1));
              count_d = count_q - CW'(1);
              state_d = S_COPY;
            end
          end
          OP_KEEP: begin
            if (n_ext > depth_ext) begin
              res_st_d = ST_RANGE;
            end else if (cnt_ext > n_ext) begin
              src_d   = AW'(cnt_ext - n_ext);
              dst_d   = '0;
              rem_d   = CW'(n_ext);
              count_d = CW'(n_ext);
              state_d = S_COPY;
            end
          end
          OP_REMOVE: begin
            if (n_ext > depth_ext) begin
              res_st_d = ST_RANGE;
            end else if (n_ext == '0) begin
              count_d = count_q;
            end else if (n_ext >= cnt_ext) begin
              count_d = (count_q != '0) ? CW'(1) : '0;
            end else begin
              count_d = CW'(cnt_ext - n_ext);
            end
          end
          default: begin
            res_st_d = ST_RANGE;
          end
        endcase
      end
      S_RDWAIT: begin
        state_d = S_DONE;
        if (op_q == OP_MOVE) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(count_q);
          count_d   = count_q + CW'(1);
        end else begin
          res_x_d = 16'(signed'(rd_eff[COORD_BITS-1:0]));
          res_y_d = 16'(signed'(rd_eff[EW-1:COORD_BITS]));
        end
      end
      S_COPY: begin
        ram_wdata = rd_eff;
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pdst_q;
        end
        if (rem_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = src_q;
          src_d     = src_q + AW'(1);
          dst_d     = dst_q + AW'(1);
          pdst_d    = dst_q;
          pend_d    = 1'b1;
          rem_d     = rem_q - CW'(1);
        end else if (!pend_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign e0_d  = e0_q || (ram_we && (ram_waddr == '0));
  assign rdz_d = ram_re && (ram_raddr == '0) && !e0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CW'(1);
      rem_q       <= '0;
      pend_q      <= 1'b0;
      e0_q        <= 1'b0;
      rdz_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      pend_q  <= pend_d;
      e0_q    <= e0_d;
      rdz_q   <= rdz_d;
      if (state_q == S_DONE && out_slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q    <= src_d;
    dst_q    <= dst_d;
    pdst_q   <= pdst_d;
    res_x_q  <= res_x_d;
    res_y_q  <= res_y_d;
    res_st_q <= res_st_d;
    if (state_q == S_IDLE && in_valid_i) begin
      op_q  <= opcode_e'(opcode_i);
      sx_q  <= step_x_i;
      sy_q  <= step_y_i;
      idx_q <= entry_index_i;
      n_q   <= entry_count_i;
    end
    if (state_q == S_DONE && out_slot_free) begin
      out_x_q    <= res_x_q;
      out_y_q    <= res_y_q;
      out_st_q   <= res_st_q;
      out_fill_q <= 7'(count_q);
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign status_o     = out_st_q;
  assign fill_count_o = out_fill_q;

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    NW'(count_q) <= NW'(DEPTH))
    else $error("Entry count exceeds the store depth.");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("Store written while no request is in progress.");

  a_pend_in_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_COPY))
    else $error("Copy data pending outside the copy sequence.");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("Result presented without a finished request.");
`endif

endmodule

// ===== hdl/phs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module phs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/phs_coord_add.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate adder
// Adds a signed step to both coordinates of a stored position, wrapping.
// ----------------------------------------------------------------------------
module phs_coord_add
  import phs_pkg::*;
(
  input  logic [EW-1:0] base_i,
  input  logic [15:0]   step_x_i,
  input  logic [15:0]   step_y_i,
  output logic [EW-1:0] sum_o
);

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;

  assign dx = COORD_BITS'(signed'(step_x_i));
  assign dy = COORD_BITS'(signed'(step_y_i));

  assign sum_o = {base_i[EW-1:COORD_BITS] + dy, base_i[COORD_BITS-1:0] + dx};

endmodule

// ===== tb/position_history_stack_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position history stack testbench
// Sends directed and random requests through the valid/ready handshake,
// predicts every result with a behavioral copy of the history and compares
// each returned result field by field, under several idling patterns.
// ----------------------------------------------------------------------------
module position_history_stack_top_tb
  import phs_pkg::*;
();

  localparam logic [2:0] OP_RESERVED_6 = 3'd6;
  localparam logic [2:0] OP_RESERVED_7 = 3'd7;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    status_e     status;
    logic [6:0]  fill;
  } history_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  opcode_i;
  logic [15:0] step_x_i;
  logic [15:0] step_y_i;
  logic [5:0]  entry_index_i;
  logic [6:0]  entry_count_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] out_x_o;
  logic [15:0] out_y_o;
  logic [1:0]  status_o;
  logic [6:0]  fill_count_o;

  logic [15:0] hist_x [DEPTH];
  logic [15:0] hist_y [DEPTH];
  int unsigned hist_len;

  history_result_t pending_results [$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int recv_hold_cycles = 0;

  position_history_stack_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .step_x_i      (step_x_i),
    .step_y_i      (step_y_i),
    .entry_index_i (entry_index_i),
    .entry_count_i (entry_count_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .status_o      (status_o),
    .fill_count_o  (fill_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Applies one request to the expected history and returns its result.
  function automatic history_result_t apply_history_op(input logic [2:0] op,
                                                       input logic [15:0] sx,
                                                       input logic [15:0] sy,
                                                       input logic [5:0] idx,
                                                       input logic [6:0] cnt);
    history_result_t res;
    logic [15:0] base_x;
    logic [15:0] base_y;
    int unsigned excess;
    res = '0;
    res.status = ST_DONE;
    case (op)
      OP_MOVE: begin
        if (hist_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          base_x = (hist_len > 0) ? hist_x[hist_len - 1] : 16'd0;
          base_y = (hist_len > 0) ? hist_y[hist_len - 1] : 16'd0;
          hist_x[hist_len] = base_x + sx;
          hist_y[hist_len] = base_y + sy;
          hist_len++;
        end
      end
      OP_DROP: begin
        if (hist_len == 0) res.status = ST_EMPTY;
        else hist_len--;
      end
      OP_POP: begin
        if (hist_len == 0) begin
          res.status = ST_EMPTY;
          res.x = 16'hFFFF;
          res.y = 16'hFFFF;
        end else begin
          hist_len--;
          res.x = hist_x[hist_len];
          res.y = hist_y[hist_len];
        end
      end
      OP_DELETE: begin
        if (idx >= hist_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = idx; i + 1 < hist_len; i++) begin
            hist_x[i] = hist_x[i + 1];
            hist_y[i] = hist_y[i + 1];
          end
          hist_len--;
        end
      end
      OP_KEEP: begin
        if (cnt > DEPTH) begin
          res.status = ST_RANGE;
        end else if (hist_len > cnt) begin
          excess = hist_len - cnt;
          for (int i = 0; i < cnt; i++) begin
            hist_x[i] = hist_x[i + excess];
            hist_y[i] = hist_y[i + excess];
          end
          hist_len = cnt;
        end
      end
      OP_REMOVE: begin
        if (cnt > DEPTH) begin
          res.status = ST_RANGE;
        end else if (cnt != 0) begin
          if (cnt >= hist_len) hist_len = (hist_len > 0) ? 1 : 0;
          else hist_len -= cnt;
        end
      end
      default: begin
        res.status = ST_RANGE;
      end
    endcase
    res.fill = hist_len[6:0];
    return res;
  endfunction

  function automatic logic [15:0] random_step();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_request(input logic [2:0] op, input logic [15:0] sx,
                              input logic [15:0] sy, input logic [5:0] idx,
                              input logic [6:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    step_x_i      <= sx;
    step_y_i      <= sy;
    entry_index_i <= idx;
    entry_count_i <= cnt;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_history_op(op, sx, sy, idx, cnt));
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Result checker and receiver ready driver.
  initial begin
    history_result_t want;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("Result arrived with no request outstanding.");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_x_o !== want.x) begin
            $error("out_x mismatch: expected %h, got %h", want.x, out_x_o);
            error_count++;
          end
          if (out_y_o !== want.y) begin
            $error("out_y mismatch: expected %h, got %h", want.y, out_y_o);
            error_count++;
          end
          if (status_o !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, status_o);
            error_count++;
          end
          if (fill_count_o !== want.fill) begin
            $error("fill_count mismatch: expected %0d, got %0d", want.fill,
                   fill_count_o);
            error_count++;
          end
        end
      end
      if (recv_hold_cycles > 0) begin
        recv_hold_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic test_directed_ops();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_request(OP_POP, 16'h0, 16'h0, 6'd0, 7'd0);
    send_request(OP_POP, 16'h0, 16'h0, 6'd0, 7'd0);
    send_request(OP_DROP, 16'h0, 16'h0, 6'd0, 7'd0);
    send_request(OP_DELETE, 16'h0, 16'h0, 6'd0, 7'd0);
    send_request(OP_REMOVE, 16'h0, 16'h0, 6'd0, 7'd5);
    send_request(OP_MOVE, 16'h7FFF, 16'h8000, 6'd0, 7'd0);
    send_request(OP_MOVE, 16'h0001, 16'hFFFF, 6'd0, 7'd0);
    send_request(OP_MOVE, 16'hFFFF, 16'h0001, 6'd0, 7'd0);
    send_request(OP_MOVE, 16'h8000, 16'h7FFF, 6'd0, 7'd0);
    send_request(OP_DELETE, 16'h0, 16'h0, 6'd63, 7'd0);
    send_request(OP_DELETE, 16'h0, 16'h0, 6'd3, 7'd0);
    send_request(OP_DELETE, 16'h0, 16'h0, 6'd0, 7'd0);
    send_request(OP_KEEP, 16'h0, 16'h0, 6'd0, 7'd65);
    send_request(OP_KEEP, 16'h0, 16'h0, 6'd0, 7'd127);
    send_request(OP_KEEP, 16'h0, 16'h0, 6'd0, 7'd64);
    send_request(OP_MOVE, 16'h1234, 16'hFFFB, 6'd0, 7'd0);
    send_request(OP_KEEP, 16'h0, 16'h0, 6'd0, 7'd2);
    send_request(OP_REMOVE, 16'h0, 16'h0, 6'd0, 7'd0);
    send_request(OP_REMOVE, 16'h0, 16'h0, 6'd0, 7'd65);
    send_request(OP_REMOVE, 16'h0, 16'h0, 6'd0, 7'd1);
    send_request(OP_MOVE, 16'hFFFF, 16'hFFFF, 6'd0, 7'd0);
    send_request(OP_MOVE, 16'h8000, 16'h8000, 6'd0, 7'd0);
    send_request(OP_REMOVE, 16'h0, 16'h0, 6'd0, 7'd64);
    send_request(OP_RESERVED_6, 16'hFFFF, 16'hFFFF, 6'd63, 7'd127);
    send_request(OP_RESERVED_7, 16'h0, 16'h0, 6'd0, 7'd0);
    send_request(OP_POP, 16'h0, 16'h0, 6'd0, 7'd0);
    wait_for_results();
  endtask

  task automatic test_fill_and_overflow();
    send_idle_pct = 10;
    recv_stall_pct = 10;
    while (hist_len < DEPTH) send_request(OP_MOVE, random_step(), random_step(), 6'd0, 7'd0);
    send_request(OP_MOVE, 16'h0001, 16'h0001, 6'd0, 7'd0);
    send_request(OP_MOVE, 16'h7FFF, 16'h8000, 6'd0, 7'd0);
    send_request(OP_POP, 16'h0, 16'h0, 6'd0, 7'd0);
    send_request(OP_MOVE, random_step(), random_step(), 6'd0, 7'd0);
    send_request(OP_DELETE, 16'h0, 16'h0, 6'd0, 7'd0);
    send_request(OP_MOVE, random_step(), random_step(), 6'd0, 7'd0);
    send_request(OP_KEEP, 16'h0, 16'h0, 6'd0, 7'd63);
    send_request(OP_DELETE, 16'h0, 16'h0, 6'd62, 7'd0);
    send_request(OP_KEEP, 16'h0, 16'h0, 6'd0, 7'd0);
    send_request(OP_MOVE, random_step(), random_step(), 6'd0, 7'd0);
    send_request(OP_DROP, 16'h0, 16'h0, 6'd0, 7'd0);
    send_request(OP_REMOVE, 16'h0, 16'h0, 6'd0, 7'd64);
    send_request(OP_DROP, 16'h0, 16'h0, 6'd0, 7'd0);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_items, input int move_weight);
    logic [2:0] op;
    logic [5:0] idx;
    logic [6:0] cnt;
    int pick;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      if (pick < move_weight) op = OP_MOVE;
      else if (pick >= 97) op = (pick[0]) ? OP_RESERVED_7 : OP_RESERVED_6;
      else op = 3'($urandom_range(5, 1));
      if (hist_len > 0 && $urandom_range(3) != 0) idx = 6'($urandom_range(hist_len - 1));
      else idx = 6'($urandom_range(63));
      case ($urandom_range(7))
        0: cnt = 7'($urandom_range(127));
        1: cnt = 7'($urandom_range(DEPTH + 1, DEPTH - 1));
        2: cnt = 7'($urandom_range(3));
        default: cnt = 7'($urandom_range(hist_len + 1));
      endcase
      send_request(op, random_step(), random_step(), idx, cnt);
    end
    wait_for_results();
  endtask

  task automatic test_backpressure();
    recv_hold_cycles = 300;
    test_random_traffic(0, 0, 40, 60);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    opcode_i      <= OP_MOVE;
    step_x_i      <= '0;
    step_y_i      <= '0;
    entry_index_i <= '0;
    entry_count_i <= '0;
    for (int i = 0; i < DEPTH; i++) begin
      hist_x[i] = '0;
      hist_y[i] = '0;
    end
    hist_len = 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_ops();
    test_fill_and_overflow();
    test_random_traffic(0, 0, 70, 55);
    test_random_traffic(66, 0, 70, 65);
    test_random_traffic(0, 66, 70, 50);
    test_random_traffic(23, 23, 70, 75);
    test_backpressure();
    repeat (100) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/phs_pkg.sv
hdl/phs_ram.sv
hdl/phs_coord_add.sv
hdl/position_history_stack_top.sv
tb/position_history_stack_top_tb.sv
